### src/lisw_pkg.sv
package lisw_pkg;

   localparam int DEPTH      = 4096;
   localparam int VALUE_BITS = 20;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int COUNT_BITS = ADDR_BITS + 1;
   localparam int TAIL_BITS  = ((VALUE_BITS > COUNT_BITS) ? VALUE_BITS : COUNT_BITS) + 1;

   typedef struct packed {
      logic                  first;
      logic [VALUE_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] length;
      logic                  overflow;
   } rsp_type;

endpackage

### src/lis_with_wildcards.sv
// Longest strictly increasing subsequence of a value stream, zero is a wildcard.
// Input channel req_*: one transaction per element; req.first opens a new sequence.
// Result channel rsp_*: exactly one transaction per input, the running length and
// the overflow flag (set once more than DEPTH elements were offered in one sequence).
// Order of work: a wildcard or an ignored element goes from acceptance straight to
// the result state; a nonzero value first runs a binary search of P probes into the
// tail memory, at most log2(DEPTH)+1, and writes its tail before the result state.
// Each probe is one read of the single-port tail memory, whose registered read
// data is compared while the next address goes out in the same cycle.
// One element is in work at a time: req_stall rises after acceptance and stays
// high until the result is loaded into the output register, so a new element
// is taken only once the result of the last one has been loaded.
// A finished result waits in the output register while rsp_stall is high; the
// next element may be accepted meanwhile, and its result waits until the slot frees.
// Reset clears counts, flag and handshake state; the tail memory is not cleared,
// since entries beyond the tail count are never read.
module lis_with_wildcards (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lisw_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lisw_pkg::rsp_type rsp
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DONE   = 2'd2;

   localparam int CB = lisw_pkg::COUNT_BITS;
   localparam int AB = lisw_pkg::ADDR_BITS;
   localparam int TB = lisw_pkg::TAIL_BITS;

   logic signed [TB-1:0] tails_mem [lisw_pkg::DEPTH];

   logic [1:0]           state_ff, state_in;
   logic [CB-1:0]        tc_ff, tc_in;
   logic [CB-1:0]        wc_ff, wc_in;
   logic [CB-1:0]        ic_ff, ic_in;
   logic                 ovf_ff, ovf_in;
   logic [CB-1:0]        lo_ff, lo_in;
   logic [CB-1:0]        hi_ff, hi_in;
   logic [CB-1:0]        mid_ff, mid_in;
   logic                 pend_ff, pend_in;
   logic signed [TB-1:0] x_ff, x_in;
   logic signed [TB-1:0] rd_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   lisw_pkg::rsp_type    rsp_ff, rsp_in;

   logic                 req_take;
   logic                 out_free;
   logic [CB-1:0]        tc_eff, wc_eff, ic_eff;
   logic                 lt;
   logic [CB-1:0]        lo_n, hi_n, mid_n;
   logic                 mem_re, mem_we;
   logic [AB-1:0]        mem_raddr, mem_waddr;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign tc_eff = req.first ? '0 : tc_ff;
   assign wc_eff = req.first ? '0 : wc_ff;
   assign ic_eff = req.first ? '0 : ic_ff;

   assign lt    = rd_data_ff < x_ff;
   assign lo_n  = (pend_ff && lt) ? (mid_ff + CB'(1)) : lo_ff;
   assign hi_n  = (pend_ff && !lt) ? mid_ff : hi_ff;
   assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

   always_comb begin
      state_in     = state_ff;
      tc_in        = tc_ff;
      wc_in        = wc_ff;
      ic_in        = ic_ff;
      ovf_in       = ovf_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      pend_in      = pend_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_raddr    = mid_n[AB-1:0];
      mem_waddr    = lo_n[AB-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               tc_in   = tc_eff;
               wc_in   = wc_eff;
               ic_in   = ic_eff;
               ovf_in  = req.first ? 1'b0 : ovf_ff;
               lo_in   = '0;
               hi_in   = tc_eff;
               pend_in = 1'b0;
               x_in    = $signed(TB'(req.value)) - $signed(TB'(wc_eff));
               if (ic_eff >= CB'(lisw_pkg::DEPTH)) begin
                  ovf_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (req.value == '0) begin
                  ic_in    = ic_eff + CB'(1);
                  wc_in    = wc_eff + CB'(1);
                  state_in = ST_DONE;
               end else begin
                  ic_in    = ic_eff + CB'(1);
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            lo_in = lo_n;
            hi_in = hi_n;
            if (lo_n < hi_n) begin
               mem_re  = 1'b1;
               mid_in  = mid_n;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (lo_n < CB'(lisw_pkg::DEPTH)) begin
                  mem_we = 1'b1;
                  if (lo_n == tc_ff) begin
                     tc_in = tc_ff + CB'(1);
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_in.length   = tc_ff + wc_ff;
               rsp_in.overflow = ovf_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tails_mem[mem_waddr] <= x_ff;
      end
      if (mem_re) begin
         rd_data_ff <= tails_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tc_ff        <= '0;
         wc_ff        <= '0;
         ic_ff        <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tc_ff        <= tc_in;
         wc_ff        <= wc_in;
         ic_ff        <= ic_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      x_ff   <= x_in;
      rsp_ff <= rsp_in;
   end

endmodule

### src/lisw_checker.sv
module lisw_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input lisw_pkg::req_type req,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lisw_pkg::rsp_type rsp
);

   // one element in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted a transaction without raising req_stall");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("handshake not idle after reset");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.length <= lisw_pkg::COUNT_BITS'(lisw_pkg::DEPTH))
      else $error("length beyond DEPTH");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled result transaction changed");

   // no result shows right after a new sequence is accepted while no result was pending
   a_first_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.first && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early after a new sequence");

endmodule

bind lis_with_wildcards lisw_checker u_lisw_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);
